// ----- rtl/core/drks_pkg.sv -----
// shared types, tables and bit selection functions for the des round key schedule
`default_nettype none
package drks_pkg;

   localparam int KEY_BITS  = 64;
   localparam int PC1_BITS  = 56;
   localparam int PC2_BITS  = 48;
   localparam int HALF_BITS = 28;
   localparam int ROUNDS    = 16;
   localparam int IDX_BITS  = $clog2(ROUNDS);

   localparam logic [IDX_BITS-1:0] LAST_ROUND = IDX_BITS'(ROUNDS - 1);

   typedef logic [HALF_BITS-1:0] half_type;
   typedef logic [PC2_BITS-1:0]  subkey_type;
   typedef logic [IDX_BITS-1:0]  round_type;

   typedef struct packed {
      half_type c;
      half_type d;
   } halves_type;

   localparam logic [6:0] PC1_TAB [PC1_BITS] = '{
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
      7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
      7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
      7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
      7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
      7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
      7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
      7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
   };

   localparam logic [5:0] PC2_TAB [PC2_BITS] = '{
      6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
      6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
      6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
      6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
      6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
      6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
   };

   // one means a rotation by two, zero a rotation by one
   localparam logic [ROUNDS-1:0] SHIFT_TWO = 16'b0111_1110_1111_1100;

   function automatic halves_type pc1(input logic [KEY_BITS-1:0] key);
      logic [PC1_BITS-1:0] r;
      logic [5:0]          idx;
      r = '0;
      for (int i = 0; i < PC1_BITS; i++) begin
         idx = 6'(KEY_BITS - int'(PC1_TAB[i]));
         r[PC1_BITS-1-i] = key[idx];
      end
      return halves_type'(r);
   endfunction

   function automatic subkey_type pc2(input halves_type h);
      logic [PC1_BITS-1:0] src;
      subkey_type          r;
      logic [5:0]          idx;
      src = h;
      r = '0;
      for (int i = 0; i < PC2_BITS; i++) begin
         idx = 6'(PC1_BITS - int'(PC2_TAB[i]));
         r[PC2_BITS-1-i] = src[idx];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/des_round_key_schedule_top.sv -----
// top level of the des round key schedule
`default_nettype none
// Each accepted 64-bit key yields sixteen 48-bit round keys, one word per cycle
// while rsp_stall is low, on the rsp channel, tagged with round index 0..15 and
// marked last on the sixteenth. The halves register and the round counter step
// once per emitted word; the next key is taken in the same cycle its
// predecessor's last round key is produced, so keys follow with no gap when
// rsp_stall stays low. An accepted key is loaded into the halves register, and
// its first round key is then registered into the output. Parity bits are ignored.
module des_round_key_schedule_top (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  [63:0]                req_cipher_key,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output drks_pkg::subkey_type       rsp_round_key,
   output drks_pkg::round_type        rsp_round_index,
   output logic                       rsp_last_round
);
   import drks_pkg::*;

   halves_type halves_ff, halves_in, step_halves;
   subkey_type step_key;
   round_type  round_ff, round_in;
   logic       busy_ff, busy_in;
   logic       rsp_valid_ff, rsp_valid_in;
   subkey_type key_ff;
   round_type  index_ff;
   logic       last_ff;
   logic       advance, finish, accept;

   drks_round u_round (
      .cur    (halves_ff),
      .round  (round_ff),
      .nxt    (step_halves),
      .subkey (step_key)
   );

   always_comb begin
      advance = busy_ff && (!rsp_valid_ff || !rsp_stall);
      finish  = advance && (round_ff == LAST_ROUND);
      req_stall = busy_ff && !finish;
      accept  = req_valid && !req_stall;

      halves_in = halves_ff;
      round_in  = round_ff;
      busy_in   = busy_ff;
      if (accept) begin
         halves_in = pc1(req_cipher_key);
         round_in  = '0;
         busy_in   = 1'b1;
      end else if (advance) begin
         halves_in = step_halves;
         round_in  = round_ff + 1'b1;
         if (finish) begin
            busy_in = 1'b0;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      halves_ff <= halves_in;
      if (advance) begin
         key_ff   <= step_key;
         index_ff <= round_ff;
         last_ff  <= (round_ff == LAST_ROUND);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_round_key   = key_ff;
   assign rsp_round_index = index_ff;
   assign rsp_last_round  = last_ff;

   // a new key always starts at the first round
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (busy_ff && round_ff == '0))
      else $error("accepted key did not start at round zero");

   // the last flag marks exactly the sixteenth word
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_round == (rsp_round_index == LAST_ROUND)))
      else $error("last flag disagrees with round index");

   // a key in progress is not dropped before its last round
   a_busy_holds: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !(advance && round_ff == LAST_ROUND)) |=> busy_ff)
      else $error("schedule stopped before the last round");

endmodule
`default_nettype wire

// ----- rtl/core/drks_round.sv -----
// one round of the schedule: rotate both halves and compress them into the round key
`default_nettype none
module drks_round (
   input  drks_pkg::halves_type cur,
   input  drks_pkg::round_type  round,
   output drks_pkg::halves_type nxt,
   output drks_pkg::subkey_type subkey
);
   import drks_pkg::*;

   always_comb begin
      if (SHIFT_TWO[round]) begin
         nxt.c = {cur.c[HALF_BITS-3:0], cur.c[HALF_BITS-1:HALF_BITS-2]};
         nxt.d = {cur.d[HALF_BITS-3:0], cur.d[HALF_BITS-1:HALF_BITS-2]};
      end else begin
         nxt.c = {cur.c[HALF_BITS-2:0], cur.c[HALF_BITS-1]};
         nxt.d = {cur.d[HALF_BITS-2:0], cur.d[HALF_BITS-1]};
      end
      subkey = pc2(nxt);
   end

endmodule
`default_nettype wire
